// ----- sv/aescfb_pkg.sv -----
// Shared constants, types and AES helper functions for the CFB-128 byte stream.
// No dependencies; the key schedule, round and top files import this package.
package aescfb_pkg;

  localparam int BlockBytes = 16;

  localparam logic [2:0] RegKeyMode = 3'd0;
  localparam logic [2:0] RegKey0    = 3'd1;
  localparam logic [2:0] RegKey1    = 3'd2;
  localparam logic [2:0] RegKey2    = 3'd3;
  localparam logic [2:0] RegKey3    = 3'd4;
  localparam logic [2:0] RegIvUpper = 3'd5;
  localparam logic [2:0] RegIvLower = 3'd6;

  localparam logic [1:0] KeyMode128 = 2'd0;
  localparam logic [1:0] KeyMode192 = 2'd1;

  typedef struct packed {
    logic init;
    logic step;
  } ks_ctrl_t;

  typedef struct packed {
    logic load;
    logic round;
    logic last;
  } rnd_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [3:0] key_nk(input logic [1:0] mode);
    logic [3:0] nk;
    case (mode)
      KeyMode128: nk = 4'd4;
      KeyMode192: nk = 4'd6;
      default:    nk = 4'd8;
    endcase
    return nk;
  endfunction

endpackage

// ----- sv/aescfb_if.sv -----
// Valid/ready channel interfaces for the byte stream input and result items.
// Standalone; no package dependency.
interface aescfb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface aescfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface

// ----- sv/aescfb_key_sched.sv -----
// Iterative AES key expansion: produces one round key word per step.
// Depends on aescfb_pkg for the S-box, round constants and control struct.
module aescfb_key_sched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aescfb_pkg::ks_ctrl_t ctrl_i,
  input  logic [1:0]          key_mode_i,
  input  logic [255:0]        key_i,
  output logic [31:0]         word_o
);
  import aescfb_pkg::*;

  logic [31:0] win_q [8];
  logic [2:0]  kcnt_q, kcnt_d;
  logic [3:0]  rc_q, rc_d;
  logic [3:0]  nk;
  logic [2:0]  old_idx;
  logic [31:0] prev, t;
  logic [7:0]  key_sel;

  assign nk      = key_nk(key_mode_i);
  assign old_idx = 3'(4'd8 - nk);
  assign prev    = win_q[7];
  assign key_sel = 8'(255) - {kcnt_q, 5'b0};

  always_comb begin
    if (kcnt_q == 3'd0) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon(rc_q), 24'h0};
    end else if (nk == 4'd8 && kcnt_q == 3'd4) begin
      t = sub_word(prev);
    end else begin
      t = prev;
    end
    if (rc_q == 4'd0) begin
      word_o = key_i[key_sel -: 32];
    end else begin
      word_o = win_q[old_idx] ^ t;
    end
    if ({1'b0, kcnt_q} == nk - 4'd1) begin
      kcnt_d = 3'd0;
      rc_d   = rc_q + 4'd1;
    end else begin
      kcnt_d = kcnt_q + 3'd1;
      rc_d   = rc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcnt_q <= 3'd0;
      rc_q   <= 4'd0;
    end else if (ctrl_i.init) begin
      kcnt_q <= 3'd0;
      rc_q   <= 4'd0;
    end else if (ctrl_i.step) begin
      kcnt_q <= kcnt_d;
      rc_q   <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      for (int j = 0; j < 7; j++) begin
        win_q[j] <= win_q[j+1];
      end
      win_q[7] <= word_o;
    end
  end

  rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) rc_q <= 4'd14)
    else $error("Round constant index out of range.");
  kcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |-> {1'b0, kcnt_q} < nk) else $error("Key word counter passed the key length.");
  init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.init |=> (kcnt_q == 3'd0 && rc_q == 4'd0)) else $error("Init did not clear.");

endmodule

// ----- sv/aescfb_round.sv -----
// AES block state register with the shared single-round datapath.
// Depends on aescfb_pkg for the S-box, xtime and control struct.
module aescfb_round (
  input  logic                 clk_i,
  input  aescfb_pkg::rnd_ctrl_t ctrl_i,
  input  logic [127:0]         block_i,
  input  logic [127:0]         key_i,
  output logic [127:0]         state_o
);
  import aescfb_pkg::*;

  logic [127:0] st_q, st_d;
  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mc [16];
  logic [7:0]   a0, a1, a2, a3, al;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[st_q[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[c*4+r] = sb[((c + r) % 4) * 4 + r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr[c*4];
      a1 = sr[c*4+1];
      a2 = sr[c*4+2];
      a3 = sr[c*4+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
      mc[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) begin
      st_d[127-8*i -: 8] = (ctrl_i.last ? sr[i] : mc[i]) ^ key_i[127-8*i -: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      st_q <= block_i ^ key_i;
    end else if (ctrl_i.round) begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

// ----- sv/aes_cfb128_byte_stream_top.sv -----
// Top level of the byte-wide AES CFB-128 stream cipher with its APB register port.
// Depends on aescfb_pkg, aescfb_if, aescfb_key_sched and aescfb_round.
//
// Each input item carries one byte and an operation bit (encrypt or decrypt); each
// item yields exactly one result item holding that byte XORed with the keystream.
// Key size, key and IV must be written over APB only while the stream is idle; the
// block does not enforce it. An IV write loads feedback and restarts the keystream.
// An item that still has keystream bytes left is answered in the cycle after it is
// accepted, and the next item may be accepted in the following cycle.
// The first item after reset, an IV write or sixteen bytes first runs one AES block:
// one key schedule word is made per cycle, and a round is applied each time the four
// words of its round key are complete, for 128, 192 or 256-bit keys.
// Reset clears the control, key, IV and feedback registers, so the feedback block
// is zero and the next item starts a new block. The result sits in an output register;
// while the receiver stalls it holds; no further item is accepted until it is free.
module aes_cfb128_byte_stream_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  aescfb_in_if.sink    in_i,
  aescfb_out_if.source out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import aescfb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_GEN, S_EMIT} state_e;

  state_e       state_q;
  logic [1:0]   key_mode_q;
  logic [63:0]  key_q [4];
  logic [63:0]  iv_up_q, iv_lo_q;
  logic [127:0] fb_q, ks_q;
  logic [4:0]   pos_q;
  logic         op_q;
  logic [7:0]   data_q;
  logic         out_valid_q;
  logic [7:0]   res_q;
  logic [5:0]   wc_q;
  logic [95:0]  rk_q;

  logic         wr_en, out_free, accept, out_set;
  logic [2:0]   reg_idx;
  logic [3:0]   nr;
  logic [31:0]  key_word;
  logic [127:0] round_key, rnd_state, ks_sel;
  ks_ctrl_t     ks_ctrl;
  rnd_ctrl_t    rnd_ctrl;
  logic         proc_op;
  logic [7:0]   proc_data, proc_res, proc_cb;
  logic [3:0]   proc_pos;
  logic [6:0]   proc_bit;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[5:3];
  assign wr_en    = psel && penable && pwrite;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign out_set  = (accept && !pos_q[4]) || (state_q == S_EMIT && out_free);
  assign nr       = key_nk(key_mode_q) + 4'd6;

  always_comb begin
    case (reg_idx)
      RegKeyMode: prdata = {62'h0, key_mode_q};
      RegKey0:    prdata = key_q[0];
      RegKey1:    prdata = key_q[1];
      RegKey2:    prdata = key_q[2];
      RegKey3:    prdata = key_q[3];
      RegIvUpper: prdata = iv_up_q;
      RegIvLower: prdata = iv_lo_q;
      default:    prdata = 64'h0;
    endcase
  end

  assign ks_ctrl.init = accept && pos_q[4];
  assign ks_ctrl.step = (state_q == S_GEN);

  aescfb_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ks_ctrl),
    .key_mode_i (key_mode_q),
    .key_i      ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .word_o     (key_word)
  );

  assign round_key      = {rk_q, key_word};
  assign rnd_ctrl.load  = (state_q == S_GEN) && (wc_q[1:0] == 2'd3) && (wc_q[5:2] == 4'd0);
  assign rnd_ctrl.round = (state_q == S_GEN) && (wc_q[1:0] == 2'd3) && (wc_q[5:2] != 4'd0);
  assign rnd_ctrl.last  = (wc_q[5:2] == nr);

  aescfb_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (rnd_ctrl),
    .block_i (fb_q),
    .key_i   (round_key),
    .state_o (rnd_state)
  );

  always_comb begin
    if (state_q == S_EMIT) begin
      ks_sel    = rnd_state;
      proc_op   = op_q;
      proc_data = data_q;
      proc_pos  = 4'd0;
    end else begin
      ks_sel    = ks_q;
      proc_op   = in_i.operation;
      proc_data = in_i.data_byte;
      proc_pos  = pos_q[3:0];
    end
    proc_bit = 7'd127 - {proc_pos, 3'b000};
    proc_res = proc_data ^ ks_sel[proc_bit -: 8];
    proc_cb  = proc_op ? proc_data : proc_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_mode_q  <= 2'd0;
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= 64'h0;
      end
      iv_up_q     <= 64'h0;
      iv_lo_q     <= 64'h0;
      fb_q        <= 128'h0;
      pos_q       <= 5'(BlockBytes);
      out_valid_q <= 1'b0;
      wc_q        <= 6'd0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        case (reg_idx)
          RegKeyMode: key_mode_q <= pwdata[1:0];
          RegKey0:    key_q[0] <= pwdata;
          RegKey1:    key_q[1] <= pwdata;
          RegKey2:    key_q[2] <= pwdata;
          RegKey3:    key_q[3] <= pwdata;
          RegIvUpper: begin
            iv_up_q       <= pwdata;
            fb_q[127:64]  <= pwdata;
            pos_q         <= 5'(BlockBytes);
          end
          RegIvLower: begin
            iv_lo_q       <= pwdata;
            fb_q[63:0]    <= pwdata;
            pos_q         <= 5'(BlockBytes);
          end
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (pos_q[4]) begin
              state_q <= S_GEN;
              wc_q    <= 6'd0;
            end else begin
              fb_q[proc_bit -: 8] <= proc_cb;
              pos_q       <= pos_q + 5'd1;
            end
          end
        end
        S_GEN: begin
          wc_q <= wc_q + 6'd1;
          if (rnd_ctrl.round && rnd_ctrl.last) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            fb_q[proc_bit -: 8] <= proc_cb;
            pos_q       <= 5'd1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q[4]) begin
      op_q   <= in_i.operation;
      data_q <= in_i.data_byte;
    end
    if (state_q == S_GEN) begin
      rk_q <= {rk_q[63:0], key_word};
    end
    if (state_q == S_EMIT) begin
      ks_q <= rnd_state;
    end
    if (out_set) begin
      res_q <= proc_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_byte = res_q;

  pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= 5'd16)
    else $error("Stream position out of range.");
  ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == S_IDLE) else $error("Ready raised outside idle.");
  emit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && !wr_en) |=> (pos_q == 5'd1 && out_valid_q))
    else $error("New block did not deliver its first byte.");
  wc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) wc_q <= 6'd60)
    else $error("Key word counter ran past the schedule.");

endmodule
